@@ design/nfha_pkg.sv @@
// Shared constants, types and codes for the next-fit heap allocator.
package nfha_pkg;

    localparam int MAX_BLOCKS   = 32;
    localparam int HEADER_BYTES = 16;
    localparam int ARENA_BYTES  = 65536;

    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int CNT_W   = IDX_W + 1;
    localparam int ADDR_W  = 16;
    localparam int LIMIT_W = 17;

    localparam logic [LIMIT_W-1:0] GROW_CAP =
        LIMIT_W'((ARENA_BYTES < 65536) ? ARENA_BYTES : 65536);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(65536);
    localparam logic [ADDR_W:0]    HDR_EXT     = (ADDR_W+1)'(HEADER_BYTES);
    localparam logic [ADDR_W:0]    OFFSET_MAX  = (ADDR_W+1)'(16'hFFFF);

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD_ADDR = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] alloc_size;
        logic [ADDR_W-1:0] payload_addr;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] result_addr;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] bytes;
        logic              busy;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        entry_t           data;
    } tbl_wr_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ASCAN,
        S_AINS,
        S_APPEND,
        S_FSCAN,
        S_FUP,
        S_FDOWN,
        S_FDROP,
        S_FTAIL,
        S_DONE
    } state_t;

endpackage

@@ design/nfha_table.sv @@
// Block table register file: one write port, one read port.
module nfha_table (
    input  logic                      clk,
    input  nfha_pkg::tbl_wr_t         wr,
    input  logic [nfha_pkg::IDX_W-1:0] rd_idx,
    output nfha_pkg::entry_t          rd_data
);
    import nfha_pkg::*;

    entry_t entry_reg [MAX_BLOCKS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            entry_reg[wr.idx] <= wr.data;
        end
    end

    assign rd_data = entry_reg[rd_idx];

endmodule

@@ design/nfha_ctrl.sv @@
// Request sequencer: table scan, split insert, append, free, merge and tail trim.
module nfha_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [nfha_pkg::LIMIT_W-1:0] heap_limit,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  nfha_pkg::req_t              in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output nfha_pkg::rsp_t              out_data,
    output nfha_pkg::tbl_wr_t           tbl_wr,
    output logic [nfha_pkg::IDX_W-1:0]  tbl_rd_idx,
    input  nfha_pkg::entry_t            tbl_rd
);
    import nfha_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   cursor_reg, cursor_next;
    logic [LIMIT_W-1:0] top_reg, top_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    req_t               req_reg, req_next;
    logic [ADDR_W-1:0]  cur_start_reg, cur_start_next;
    logic [ADDR_W-1:0]  cur_bytes_reg, cur_bytes_next;
    logic [ADDR_W-1:0]  rstart_reg, rstart_next;
    logic [ADDR_W-1:0]  rest_reg, rest_next;
    logic               drop_dn_reg, drop_dn_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic [ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic               out_valid_reg, out_valid_next;
    rsp_t               out_reg, out_next;

    // shared compare and add terms
    logic               accept;
    logic [ADDR_W:0]    size_hdr;
    logic               a_exact, a_split, a_last;
    logic [LIMIT_W-1:0] limit_eff;
    logic [LIMIT_W:0]   app_end;
    logic               app_full, app_fail;
    logic               f_end, f_hit;
    logic               up_merge, dn_merge;
    logic               drop_more;
    logic               tail;
    logic               out_free;
    logic [IDX_W-1:0]   scan_wrap;

    assign accept    = in_valid && in_ready;
    assign size_hdr  = {1'b0, req_reg.alloc_size} + HDR_EXT;
    assign a_exact   = !tbl_rd.busy && (tbl_rd.bytes == req_reg.alloc_size);
    assign a_split   = !tbl_rd.busy && !a_exact && ({1'b0, tbl_rd.bytes} > size_hdr)
                       && (cnt_reg < CNT_W'(MAX_BLOCKS));
    assign a_last    = (n_reg + CNT_W'(1)) >= cnt_reg;
    assign scan_wrap = ((CNT_W'(idx_reg) + CNT_W'(1)) >= cnt_reg) ? '0 : idx_reg + IDX_W'(1);
    assign limit_eff = (heap_limit > GROW_CAP) ? GROW_CAP : heap_limit;
    assign app_end   = {1'b0, top_reg} + (LIMIT_W+1)'(HEADER_BYTES)
                       + (LIMIT_W+1)'(req_reg.alloc_size);
    assign app_full  = cnt_reg >= CNT_W'(MAX_BLOCKS);
    assign app_fail  = (app_end > {1'b0, limit_eff})
                       || ((top_reg + LIMIT_W'(HEADER_BYTES)) > LIMIT_W'(OFFSET_MAX));
    assign f_end     = n_reg >= cnt_reg;
    assign f_hit     = tbl_rd.busy
                       && (({1'b0, tbl_rd.start} + HDR_EXT) == {1'b0, req_reg.payload_addr});
    assign up_merge  = ((CNT_W'(idx_reg) + CNT_W'(1)) < cnt_reg) && !tbl_rd.busy;
    assign dn_merge  = (idx_reg != '0) && !tbl_rd.busy;
    assign drop_more = (CNT_W'(k_reg) + CNT_W'(1)) < cnt_reg;
    assign tail      = (CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // read address of the table for the current step
    always_comb
    begin
        case (state_reg)
            S_ASCAN: tbl_rd_idx = idx_reg;
            S_AINS:  tbl_rd_idx = k_reg - IDX_W'(1);
            S_FSCAN: tbl_rd_idx = n_reg[IDX_W-1:0];
            S_FUP:   tbl_rd_idx = idx_reg + IDX_W'(1);
            S_FDOWN: tbl_rd_idx = idx_reg - IDX_W'(1);
            S_FDROP: tbl_rd_idx = k_reg + IDX_W'(1);
            default: tbl_rd_idx = idx_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.req_type == REQ_FREE)
                    begin
                        state_next = S_FSCAN;
                    end
                    else if (cnt_reg == '0)
                    begin
                        state_next = S_APPEND;
                    end
                    else
                    begin
                        state_next = S_ASCAN;
                    end
                end
            end
            S_ASCAN:
            begin
                if (a_exact)
                begin
                    state_next = S_DONE;
                end
                else if (a_split)
                begin
                    state_next = S_AINS;
                end
                else if (a_last)
                begin
                    state_next = S_APPEND;
                end
            end
            S_AINS:
            begin
                if (k_reg == pos_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_APPEND: state_next = S_DONE;
            S_FSCAN:
            begin
                if (f_end)
                begin
                    state_next = S_DONE;
                end
                else if (f_hit)
                begin
                    state_next = S_FUP;
                end
            end
            S_FUP:   state_next = up_merge ? S_FDROP : S_FDOWN;
            S_FDOWN: state_next = dn_merge ? S_FDROP : S_FTAIL;
            S_FDROP:
            begin
                if (!drop_more)
                begin
                    state_next = drop_dn_reg ? S_FTAIL : S_FDOWN;
                end
            end
            S_FTAIL: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next        = cnt_reg;
        cursor_next     = cursor_reg;
        top_next        = top_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        pos_next        = pos_reg;
        req_next        = req_reg;
        cur_start_next  = cur_start_reg;
        cur_bytes_next  = cur_bytes_reg;
        rstart_next     = rstart_reg;
        rest_next       = rest_reg;
        drop_dn_next    = drop_dn_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        tbl_wr          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next        = in_data;
                    res_status_next = ST_OK;
                    res_addr_next   = '0;
                    n_next          = '0;
                    idx_next        = (CNT_W'(cursor_reg) < cnt_reg) ? cursor_reg : '0;
                end
            end
            S_ASCAN:
            begin
                if (a_exact || a_split)
                begin
                    tbl_wr.en         = 1'b1;
                    tbl_wr.idx        = idx_reg;
                    tbl_wr.data.start = tbl_rd.start;
                    tbl_wr.data.bytes = a_exact ? tbl_rd.bytes : req_reg.alloc_size;
                    tbl_wr.data.busy  = 1'b1;
                    cursor_next       = idx_reg;
                    res_addr_next     = tbl_rd.start + ADDR_W'(HEADER_BYTES);
                    rest_next         = tbl_rd.bytes - size_hdr[ADDR_W-1:0];
                    rstart_next       = tbl_rd.start + size_hdr[ADDR_W-1:0];
                    pos_next          = idx_reg + IDX_W'(1);
                    k_next            = cnt_reg[IDX_W-1:0];
                end
                else
                begin
                    n_next   = n_reg + CNT_W'(1);
                    idx_next = scan_wrap;
                end
            end
            S_AINS:
            begin
                tbl_wr.en  = 1'b1;
                tbl_wr.idx = k_reg;
                if (k_reg == pos_reg)
                begin
                    tbl_wr.data.start = rstart_reg;
                    tbl_wr.data.bytes = rest_reg;
                    tbl_wr.data.busy  = 1'b0;
                    cnt_next          = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    tbl_wr.data = tbl_rd;
                    k_next      = k_reg - IDX_W'(1);
                end
            end
            S_APPEND:
            begin
                if (app_full)
                begin
                    res_status_next = ST_FULL;
                end
                else if (app_fail)
                begin
                    res_status_next = ST_NO_SPACE;
                end
                else
                begin
                    tbl_wr.en         = 1'b1;
                    tbl_wr.idx        = cnt_reg[IDX_W-1:0];
                    tbl_wr.data.start = top_reg[ADDR_W-1:0];
                    tbl_wr.data.bytes = req_reg.alloc_size;
                    tbl_wr.data.busy  = 1'b1;
                    cursor_next       = cnt_reg[IDX_W-1:0];
                    cnt_next          = cnt_reg + CNT_W'(1);
                    top_next          = app_end[LIMIT_W-1:0];
                    res_addr_next     = top_reg[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
                end
            end
            S_FSCAN:
            begin
                if (f_end)
                begin
                    res_status_next = ST_BAD_ADDR;
                end
                else if (f_hit)
                begin
                    tbl_wr.en        = 1'b1;
                    tbl_wr.idx       = n_reg[IDX_W-1:0];
                    tbl_wr.data      = tbl_rd;
                    tbl_wr.data.busy = 1'b0;
                    idx_next         = n_reg[IDX_W-1:0];
                    cur_start_next   = tbl_rd.start;
                    cur_bytes_next   = tbl_rd.bytes;
                end
                else
                begin
                    n_next = n_reg + CNT_W'(1);
                end
            end
            S_FUP:
            begin
                if (up_merge)
                begin
                    cur_bytes_next    = cur_bytes_reg + tbl_rd.bytes + ADDR_W'(HEADER_BYTES);
                    tbl_wr.en         = 1'b1;
                    tbl_wr.idx        = idx_reg;
                    tbl_wr.data.start = cur_start_reg;
                    tbl_wr.data.bytes = cur_bytes_next;
                    tbl_wr.data.busy  = 1'b0;
                    k_next            = idx_reg + IDX_W'(1);
                    drop_dn_next      = 1'b0;
                    if ((cursor_reg >= k_next) && (cursor_reg != '0))
                    begin
                        cursor_next = cursor_reg - IDX_W'(1);
                    end
                end
            end
            S_FDOWN:
            begin
                if (dn_merge)
                begin
                    cur_bytes_next    = tbl_rd.bytes + cur_bytes_reg + ADDR_W'(HEADER_BYTES);
                    cur_start_next    = tbl_rd.start;
                    tbl_wr.en         = 1'b1;
                    tbl_wr.idx        = idx_reg - IDX_W'(1);
                    tbl_wr.data.start = tbl_rd.start;
                    tbl_wr.data.bytes = cur_bytes_next;
                    tbl_wr.data.busy  = 1'b0;
                    k_next            = idx_reg;
                    idx_next          = idx_reg - IDX_W'(1);
                    drop_dn_next      = 1'b1;
                    if ((cursor_reg >= idx_reg) && (cursor_reg != '0))
                    begin
                        cursor_next = cursor_reg - IDX_W'(1);
                    end
                end
            end
            S_FDROP:
            begin
                if (drop_more)
                begin
                    tbl_wr.en   = 1'b1;
                    tbl_wr.idx  = k_reg;
                    tbl_wr.data = tbl_rd;
                    k_next      = k_reg + IDX_W'(1);
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_FTAIL:
            begin
                if (tail)
                begin
                    top_next = {1'b0, cur_start_reg};
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (CNT_W'(cursor_reg) >= cnt_next)
                    begin
                        cursor_next = '0;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.status     = res_status_reg;
                    out_next.result_addr = res_addr_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            cursor_reg    <= '0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cursor_reg    <= cursor_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        n_reg          <= n_next;
        k_reg          <= k_next;
        pos_reg        <= pos_next;
        req_reg        <= req_next;
        cur_start_reg  <= cur_start_next;
        cur_bytes_reg  <= cur_bytes_next;
        rstart_reg     <= rstart_next;
        rest_reg       <= rest_next;
        drop_dn_reg    <= drop_dn_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        out_reg        <= out_next;
    end

endmodule

@@ design/next_fit_heap_allocator_top.sv @@
// Top level of the next-fit heap allocator with block coalescing.
//
// Manages a 64 KiB byte arena as an address-ordered table of up to 32 blocks, each
// with a 16-byte header. An allocate transaction scans the table circularly from a
// next-fit cursor, one entry per cycle, taking an exact-size free block or splitting
// a larger one; failing that it appends a block at the heap top, bounded by
// heap_limit. A free transaction searches for the busy block by payload offset, one
// entry per cycle, merges it with free neighbors and trims a free tail block.
// All work runs through one table read port and one write port under a small
// sequencer, which scans the table and, on a split or merge, shifts its entries.
// The next transaction is taken once the sequencer is idle, even
// while the previous result still waits in the output register. heap_limit is
// written through cfg_wr_en / cfg_wr_data and must only change while the block
// is idle.
module next_fit_heap_allocator_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [nfha_pkg::LIMIT_W-1:0] cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  nfha_pkg::req_t               in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output nfha_pkg::rsp_t               out_data
);
    import nfha_pkg::*;

    // growth limit register
    logic [LIMIT_W-1:0] heap_limit_reg, heap_limit_next;

    tbl_wr_t          tbl_wr;
    logic [IDX_W-1:0] tbl_rd_idx;
    entry_t           tbl_rd;

    assign heap_limit_next = cfg_wr_en ? cfg_wr_data : heap_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_limit_reg <= LIMIT_RESET;
        end
        else
        begin
            heap_limit_reg <= heap_limit_next;
        end
    end

    // sequencer: scan, split, append, free, merge and trim
    nfha_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .heap_limit (heap_limit_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .tbl_wr     (tbl_wr),
        .tbl_rd_idx (tbl_rd_idx),
        .tbl_rd     (tbl_rd)
    );

    // block table: header offset, payload size and busy bit per entry
    nfha_table u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd_idx  (tbl_rd_idx),
        .rd_data (tbl_rd)
    );

endmodule

@@ design/nfha_checker.sv @@
// Port-level checker for the next-fit heap allocator, bound to the top level.
module nfha_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input nfha_pkg::rsp_t out_data
);
    import nfha_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result changed while stalled");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != ST_OK) |-> out_data.result_addr == '0)
        else $error("failed request returned an address");

    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready while a transaction is in progress");

endmodule

bind next_fit_heap_allocator_top nfha_checker u_nfha_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

@@ verif/tb_top.sv @@
// Self-checking testbench for the next-fit heap allocator top level.
`timescale 1ns / 100ps

module tb_top;
    import nfha_pkg::*;

    localparam int SETTLE_CYCLES = 2 * MAX_BLOCKS + 16;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [LIMIT_W-1:0]  cfg_wr_data;
    logic                in_valid;
    logic                in_ready;
    req_t                in_data;
    logic                out_valid;
    logic                out_ready;
    rsp_t                out_data;

    next_fit_heap_allocator_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    // Shadow copy of the allocator: block table, cursor, heap top and limit.
    logic [ADDR_W-1:0]  shd_start [MAX_BLOCKS];
    logic [ADDR_W-1:0]  shd_bytes [MAX_BLOCKS];
    logic               shd_busy  [MAX_BLOCKS];
    int unsigned        shd_count;
    int unsigned        shd_cursor;
    int unsigned        shd_top;
    int unsigned        shd_limit;

    req_t               pending_reqs[$];
    rsp_t               expected_rsps[$];
    logic [ADDR_W-1:0]  live_addrs[$];   // payloads the stimulus believes are busy
    int                 fail_count;
    bit                 idle_on;         // random idling enabled
    bit                 hold_sender;     // stall the driver until drained

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Remove table entry j after entry j-1 absorbed it.
    function automatic void drop_block(int unsigned j);
        for (int unsigned k = j; k + 1 < shd_count; k++)
        begin
            shd_start[k] = shd_start[k+1];
            shd_bytes[k] = shd_bytes[k+1];
            shd_busy[k]  = shd_busy[k+1];
        end
        shd_count--;
        if (shd_cursor >= j && shd_cursor > 0)
            shd_cursor--;
    endfunction

    function automatic void absorb_block(int unsigned j);
        shd_bytes[j-1] = shd_bytes[j-1] + shd_bytes[j] + HEADER_BYTES;
        drop_block(j);
    endfunction

    function automatic rsp_t serve_alloc(int unsigned size);
        rsp_t        r;
        int unsigned idx;
        int unsigned lim;
        int unsigned fin;
        r.status = ST_OK;
        r.result_addr = '0;
        if (shd_count > 0)
        begin
            idx = (shd_cursor < shd_count) ? shd_cursor : 0;
            for (int unsigned n = 0; n < shd_count; n++)
            begin
                if (!shd_busy[idx])
                begin
                    if (shd_bytes[idx] == size)
                    begin
                        shd_busy[idx] = 1'b1;
                        shd_cursor = idx;
                        r.result_addr = ADDR_W'(shd_start[idx] + HEADER_BYTES);
                        return r;
                    end
                    if (shd_bytes[idx] > size + HEADER_BYTES && shd_count < MAX_BLOCKS)
                    begin
                        // Shift the table up and place the leftover behind the taken part.
                        for (int unsigned k = shd_count; k > idx + 1; k--)
                        begin
                            shd_start[k] = shd_start[k-1];
                            shd_bytes[k] = shd_bytes[k-1];
                            shd_busy[k]  = shd_busy[k-1];
                        end
                        shd_start[idx+1] = ADDR_W'(shd_start[idx] + HEADER_BYTES + size);
                        shd_bytes[idx+1] = ADDR_W'(shd_bytes[idx] - size - HEADER_BYTES);
                        shd_busy[idx+1]  = 1'b0;
                        shd_count++;
                        shd_bytes[idx] = ADDR_W'(size);
                        shd_busy[idx]  = 1'b1;
                        shd_cursor = idx;
                        r.result_addr = ADDR_W'(shd_start[idx] + HEADER_BYTES);
                        return r;
                    end
                end
                idx++;
                if (idx >= shd_count)
                    idx = 0;
            end
        end
        if (shd_count >= MAX_BLOCKS)
        begin
            r.status = ST_FULL;
            return r;
        end
        lim = shd_limit;
        if (lim > ARENA_BYTES)
            lim = ARENA_BYTES;
        if (lim > 65536)
            lim = 65536;
        fin = shd_top + HEADER_BYTES + size;
        if (fin > lim || shd_top + HEADER_BYTES > 16'hFFFF)
        begin
            r.status = ST_NO_SPACE;
            return r;
        end
        shd_start[shd_count] = ADDR_W'(shd_top);
        shd_bytes[shd_count] = ADDR_W'(size);
        shd_busy[shd_count]  = 1'b1;
        shd_cursor = shd_count;
        shd_count++;
        shd_top = fin;
        r.result_addr = ADDR_W'(shd_top - size);
        return r;
    endfunction

    function automatic rsp_t serve_free(int unsigned addr);
        rsp_t        r;
        int unsigned i;
        bit          hit;
        r.status = ST_OK;
        r.result_addr = '0;
        hit = 1'b0;
        for (i = 0; i < shd_count; i++)
        begin
            if (shd_busy[i] && shd_start[i] + HEADER_BYTES == addr)
            begin
                hit = 1'b1;
                break;
            end
        end
        if (!hit)
        begin
            r.status = ST_BAD_ADDR;
            return r;
        end
        shd_busy[i] = 1'b0;
        if (i + 1 < shd_count && !shd_busy[i+1])
            absorb_block(i + 1);
        if (i > 0 && !shd_busy[i-1])
        begin
            absorb_block(i);
            i--;
        end
        // Give a free tail back to the heap top; wrap a cursor left dangling.
        if (i + 1 == shd_count)
        begin
            shd_top = shd_start[i];
            shd_count--;
            if (shd_cursor >= shd_count)
                shd_cursor = 0;
        end
        return r;
    endfunction

    function automatic rsp_t predict_rsp(req_t rq);
        if (rq.req_type == REQ_ALLOC)
            return serve_alloc(rq.alloc_size);
        return serve_free(rq.payload_addr);
    endfunction

    // Driver: present the next queued request, hold it until the handshake.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                expected_rsps.push_back(predict_rsp(in_data));
            if (pending_reqs.size() > 0 && !hold_sender &&
                !(idle_on && $urandom_range(99) < 24))
            begin
                in_valid <= 1'b1;
                in_data  <= pending_reqs.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each response transaction with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected response status=%0d addr=%0d",
                           out_data.status, out_data.result_addr);
                    fail_count++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (out_data.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               want.status, out_data.status);
                        fail_count++;
                    end
                    if (out_data.result_addr !== want.result_addr)
                    begin
                        $error("result_addr: expected %0d, actual %0d",
                               want.result_addr, out_data.result_addr);
                        fail_count++;
                    end
                end
            end
            out_ready <= !(idle_on && $urandom_range(99) < 24);
        end
    end

    task automatic queue_alloc(int unsigned size);
        req_t rq;
        rq.req_type     = REQ_ALLOC;
        rq.alloc_size   = ADDR_W'(size);
        rq.payload_addr = ADDR_W'($urandom);
        pending_reqs.push_back(rq);
    endtask

    task automatic queue_free(int unsigned addr);
        req_t rq;
        rq.req_type     = REQ_FREE;
        rq.alloc_size   = ADDR_W'($urandom);
        rq.payload_addr = ADDR_W'(addr);
        pending_reqs.push_back(rq);
    endtask

    // Wait until everything queued has been sent and answered, then let the
    // sequencer settle before touching the limit register.
    task automatic drain_all();
        while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(int unsigned value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= LIMIT_W'(value);
        shd_limit    = value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly well-formed traffic: allocate small sizes, free ones we handed
    // out; a few bad frees, odd sizes and large requests as noise.
    task automatic queue_random(int unsigned count);
        int unsigned pick;
        int unsigned k;
        for (int unsigned n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                queue_alloc($urandom_range(3) == 0 ? $urandom_range(64) : $urandom_range(600));
            else if (pick < 85 && live_addrs.size() > 0)
            begin
                k = $urandom_range(live_addrs.size() - 1);
                queue_free(live_addrs[k]);
                live_addrs.delete(k);
            end
            else if (pick < 92)
                queue_free($urandom);
            else if (pick < 96)
                queue_alloc($urandom);
            else
                queue_alloc($urandom_range(8000));
            // Track allocations loosely: guess the payload after queueing.
            if (pick < 45)
                live_addrs.push_back(ADDR_W'(0));
        end
    endtask

    // Feed the monitor's successful allocations back into the free pool.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready && out_data.status == ST_OK &&
            out_data.result_addr != 0)
            live_addrs.push_back(out_data.result_addr);
    end

    initial
    begin
        fail_count  = 0;
        idle_on     = 1'b0;
        hold_sender = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        shd_count   = 0;
        shd_cursor  = 0;
        shd_top     = 0;
        shd_limit   = LIMIT_RESET;
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            shd_start[i] = '0;
            shd_bytes[i] = '0;
            shd_busy[i]  = 1'b0;
        end
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: appends, exact fit, split, merges, tail trim, bad frees.
        queue_alloc(0);
        queue_alloc(100);
        queue_alloc(200);
        queue_alloc(50);
        queue_free(16 + 16);       // free the 100-byte block
        queue_alloc(100);          // exact fit reuses it
        queue_free(32);
        queue_alloc(40);           // split of the 100-byte block
        queue_free(12345);         // not a payload
        queue_free(32);
        queue_free(32);            // double free
        queue_free(148);           // merge with the free lower neighbor
        queue_free(364);           // tail trim of merged region
        queue_free(16);
        queue_alloc(16'hFFFF);     // too big for the arena
        queue_alloc(16'hFFEF);     // fits; heap top becomes 65535
        queue_free(16);
        queue_free(0);
        for (int i = 0; i < 33; i++)
            queue_alloc(1);        // runs into a full table
        drain_all();

        // Drop everything and narrow the limit to the extremes.
        for (int i = 0; i < MAX_BLOCKS; i++)
            queue_free(16 + i * 17);
        drain_all();
        write_limit(0);
        queue_alloc(0);
        queue_free(16);
        drain_all();
        write_limit(LIMIT_W'('1));
        live_addrs.delete();

        // Random phases with different limits; first one runs with no idling.
        queue_random(400);
        drain_all();
        idle_on = 1'b1;
        write_limit(4096);
        live_addrs.delete();
        queue_random(450);
        // Hold the sender off until every response is back.
        while (pending_reqs.size() > 200)
            @(posedge clk);
        hold_sender = 1'b1;
        while (in_valid || expected_rsps.size() > 0)
            @(posedge clk);
        hold_sender = 1'b0;
        drain_all();
        write_limit(700);
        live_addrs.delete();
        queue_random(400);
        drain_all();
        write_limit(65536);
        live_addrs.delete();
        queue_random(500);
        drain_all();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

@@ next_fit_heap_allocator_top.f @@
design/nfha_pkg.sv
design/nfha_table.sv
design/nfha_ctrl.sv
design/next_fit_heap_allocator_top.sv
design/nfha_checker.sv
verif/tb_top.sv
